/* sv/ffs_pkg.sv */
package ffs_pkg;

	// timeouts in milliseconds
	localparam logic [31:0] LONG_TIMEOUT_MS  = 32'd20000;
	localparam logic [31:0] SHORT_TIMEOUT_MS = 32'd5000;

	// stream widths
	localparam int unsigned IN_DATA_W  = 80;
	localparam int unsigned OUT_DATA_W = 16;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_WATCH_HEARTBEAT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FORCE_KILL      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COMPANION_TYPE  = 2'd2;

	localparam logic [7:0] COMPANION_TYPE_RESET = 8'd18;

	// item kinds
	localparam logic OP_HEARTBEAT = 1'b0;
	localparam logic OP_CHECK     = 1'b1;

	// flight modes
	localparam logic [3:0] MODE_MANUAL = 4'd0;
	localparam logic [3:0] MODE_FBWA   = 4'd1;
	localparam logic [3:0] MODE_FBWB   = 4'd2;
	localparam logic [3:0] MODE_CIRCLE = 4'd3;

	typedef enum logic [2:0] {
		FS_NONE            = 3'd0,
		FS_GPS_SHORT       = 3'd1,
		FS_GPS_LONG        = 3'd2,
		FS_GPS_RECOVERING  = 3'd3,
		FS_FENCE_SECONDARY = 3'd4,
		FS_NO_COMPANION    = 3'd5
	} fs_state_t;

	typedef struct packed {
		logic       watch_heartbeat;
		logic       force_kill;
		logic [7:0] companion_type;
	} cfg_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] now_ms;
		logic [7:0]  heartbeat_type;
		logic [3:0]  flight_mode;
		logic        near_ground;
		logic [31:0] gps_fix_ms;
		logic        breach_now;
	} item_t;

	typedef struct packed {
		logic       ok;
		fs_state_t  fs_state;
		logic       kill_throttle;
		logic [3:0] saved_mode;
	} result_t;

endpackage

/* sv/ffs_cfg.sv */
module ffs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ffs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ffs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ffs_pkg::cfg_t                      cfg
);

	ffs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes, one per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watch_heartbeat <= 1'b1;
			cfg_q.force_kill      <= 1'b0;
			cfg_q.companion_type  <= ffs_pkg::COMPANION_TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffs_pkg::REG_WATCH_HEARTBEAT: cfg_q.watch_heartbeat <= cfg_data[0];
				ffs_pkg::REG_FORCE_KILL:      cfg_q.force_kill      <= cfg_data[0];
				ffs_pkg::REG_COMPANION_TYPE:  cfg_q.companion_type  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* sv/ffs_core.sv */
module ffs_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  ffs_pkg::item_t   item,
	input  ffs_pkg::cfg_t    cfg,
	output ffs_pkg::result_t result
);

	ffs_pkg::fs_state_t state_q, state_d;
	logic [31:0] hb_time_q, hb_time_d;
	logic [31:0] breach_start_q, breach_start_d;
	logic        breach_valid_q, breach_valid_d;
	logic [3:0]  prev_mode_q, prev_mode_d;
	logic        ok;

	logic [31:0] gps_age;
	logic [31:0] breach_from;
	logic [31:0] breach_age;
	logic [31:0] hb_age;
	logic        manual;
	logic        gps_lost_prior;

	assign gps_age     = item.now_ms - item.gps_fix_ms;
	assign breach_from = breach_valid_q ? breach_start_q : item.now_ms;
	assign breach_age  = item.now_ms - breach_from;
	assign hb_age      = item.now_ms - hb_time_q;
	assign manual      = (item.flight_mode == ffs_pkg::MODE_MANUAL) ||
	                     (item.flight_mode == ffs_pkg::MODE_FBWA) ||
	                     (item.flight_mode == ffs_pkg::MODE_FBWB);
	assign gps_lost_prior = (state_q == ffs_pkg::FS_GPS_LONG) ||
	                        (state_q == ffs_pkg::FS_GPS_SHORT) ||
	                        (state_q == ffs_pkg::FS_GPS_RECOVERING);

	// failsafe rules in priority order
	always_comb begin
		state_d        = state_q;
		hb_time_d      = hb_time_q;
		breach_start_d = breach_start_q;
		breach_valid_d = breach_valid_q;
		prev_mode_d    = prev_mode_q;
		ok             = 1'b0;
		if (item.operation == ffs_pkg::OP_HEARTBEAT) begin
			if (item.heartbeat_type == cfg.companion_type) begin
				hb_time_d = item.now_ms;
				ok        = 1'b1;
			end
		end else if (manual || item.near_ground) begin
			state_d = ffs_pkg::FS_NONE;
		end else if (gps_age > ffs_pkg::LONG_TIMEOUT_MS) begin
			state_d = ffs_pkg::FS_GPS_LONG;
		end else if (gps_age >= ffs_pkg::SHORT_TIMEOUT_MS) begin
			if (state_q != ffs_pkg::FS_GPS_SHORT) begin
				prev_mode_d = item.flight_mode;
			end
			state_d = ffs_pkg::FS_GPS_SHORT;
		end else if (gps_lost_prior && item.flight_mode == ffs_pkg::MODE_CIRCLE) begin
			state_d = ffs_pkg::FS_GPS_RECOVERING;
		end else begin
			// fence timer runs on every check that gets this far
			if (item.breach_now) begin
				breach_valid_d = 1'b1;
				breach_start_d = breach_from;
			end else begin
				breach_valid_d = 1'b0;
				breach_start_d = '0;
			end
			if (item.breach_now && breach_age > ffs_pkg::LONG_TIMEOUT_MS) begin
				state_d = ffs_pkg::FS_FENCE_SECONDARY;
			end else if (cfg.watch_heartbeat && hb_age > ffs_pkg::LONG_TIMEOUT_MS) begin
				state_d = ffs_pkg::FS_NO_COMPANION;
			end else begin
				state_d = ffs_pkg::FS_NONE;
				ok      = 1'b1;
			end
		end
	end

	// result reports the state after the item
	always_comb begin
		result.ok            = ok;
		result.fs_state      = state_d;
		result.kill_throttle = (state_d == ffs_pkg::FS_GPS_LONG) ||
		                       (state_d == ffs_pkg::FS_FENCE_SECONDARY) ||
		                       cfg.force_kill;
		result.saved_mode    = prev_mode_d;
	end

	// supervisor state, updated as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ffs_pkg::FS_NONE;
			hb_time_q      <= '0;
			breach_start_q <= '0;
			breach_valid_q <= 1'b0;
			prev_mode_q    <= '0;
		end else if (advance) begin
			state_q        <= state_d;
			hb_time_q      <= hb_time_d;
			breach_start_q <= breach_start_d;
			breach_valid_q <= breach_valid_d;
			prev_mode_q    <= prev_mode_d;
		end
	end

endmodule

/* sv/flight_failsafe_supervisor.sv */
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: item fields, tuser: operation
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: result fields
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// one item per cycle while results are taken; each item waits in the input register,
// where the rule logic runs on it, and then sits in the result register until taken
// supervisor state is updated as an item moves into the result register, so the
// next item in the input register always sees it
// a stalled result holds both stages; the input register still fills when empty
// reset clears valid flags, state and configuration registers to their defaults
module flight_failsafe_supervisor (
	input  logic                                clk,
	input  logic                                arst_n,
	// now_ms[31:0], heartbeat_type[39:32], flight_mode[43:40], near_ground[44],
	// gps_fix_ms[76:45], breach_now[77], zero[79:78]
	input  logic [ffs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// operation[0]
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// ok[0], fs_state[3:1], kill_throttle[4], saved_mode[8:5], zero[15:9]
	output logic [ffs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ffs_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ffs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	ffs_pkg::cfg_t    cfg;
	ffs_pkg::item_t   item_in;
	ffs_pkg::item_t   item_s1;
	logic             valid_s1;
	ffs_pkg::result_t result;
	ffs_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;

	ffs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// unpack the input transfer
	always_comb begin
		item_in.operation      = s_axis_tuser;
		item_in.now_ms         = s_axis_tdata[31:0];
		item_in.heartbeat_type = s_axis_tdata[39:32];
		item_in.flight_mode    = s_axis_tdata[43:40];
		item_in.near_ground    = s_axis_tdata[44];
		item_in.gps_fix_ms     = s_axis_tdata[76:45];
		item_in.breach_now     = s_axis_tdata[77];
	end

	// stage handshake
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	ffs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, result_s2.saved_mode, result_s2.kill_throttle,
	                        result_s2.fs_state, result_s2.ok};

endmodule
